// File: rtl/lkv_pkg.sv
// shared constants and control bundles for the lru key-value cache
package lkv_pkg;

  // default geometry
  localparam int unsigned WaysDef      = 8;
  localparam int unsigned KeyBitsDef   = 10;
  localparam int unsigned ValueBitsDef = 32;

  // capacity register
  localparam int unsigned CapBits = 4;
  localparam logic [CapBits-1:0] CapReset = 4'd8;

  // request codes
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  // way store write controls
  typedef struct packed {
    logic entry_we;   // write key and data at the write address
    logic rank_we;    // write rank at the write address
    logic set_valid;  // mark the write address valid
    logic clr_valid;  // drop the victim address
  } way_ctl_t;

  // backing store port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bk_ctl_t;

endpackage

// File: rtl/lru_key_value_cache.sv
// lru key-value cache with write-through backing store, top level and sequencer
//
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------------------
//  request   | start, busy             | operation_i, key_i, value_i
//  result    | result_valid_o          | found_o, hit_o, read_data_o, evicted_o,
//            |                         | evicted_key_o
//  config    | cfg_we_i                | cfg_data_i (capacity)
//
//  after acceptance a transaction runs compare steps over the ways (S_SCAN), a decide
//  step (S_DECIDE), a data read on a get hit (S_GRAB), then rank updates through the
//  rank memory read-modify-write path (S_RANK) before the result strobe; a get that
//  finds nothing goes from the decide step straight to the result strobe.
//  busy falls the cycle after the strobe, so no new transaction is taken until the
//  block is through with the last one.
//  after reset the backing store is swept, all 2**KEY_BITS entries (1024 by default),
//  while busy stays high; capacity writes are taken during the sweep.
//  the result is shown for one cycle and cannot be stalled.
module lru_key_value_cache #(
  parameter int unsigned WAYS       = lkv_pkg::WaysDef,
  parameter int unsigned KEY_BITS   = lkv_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = lkv_pkg::ValueBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic                         hit_o,
  output logic [VALUE_BITS-1:0]        read_data_o,
  output logic                         evicted_o,
  output logic [KEY_BITS-1:0]          evicted_key_o,
  input  logic                         cfg_we_i,
  input  logic [lkv_pkg::CapBits-1:0]  cfg_data_i
);

  localparam int unsigned WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CB = $clog2(WAYS + 1);
  localparam logic [WB:0] IdxLast = (WB + 1)'(WAYS);
  localparam logic [7:0]  WaysW   = 8'(WAYS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_GRAB,
    S_RANK,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [WB:0]                  idx_q;
  logic [lkv_pkg::CapBits-1:0]  cap_q;
  logic                         op_q;
  logic [KEY_BITS-1:0]          key_q;
  logic [VALUE_BITS-1:0]        value_q;
  logic                         hit_found_q;
  logic [WB-1:0]                hit_way_q;
  logic [WB-1:0]                hit_rank_q;
  logic [CB-1:0]                cnt_q;
  logic                         vic_found_q;
  logic [WB-1:0]                vic_way_q;
  logic [WB-1:0]                vic_rank_q;
  logic [KEY_BITS-1:0]          vic_key_q;
  logic                         free_found_q;
  logic [WB-1:0]                free_way_q;
  logic                         mode_install_q;
  logic [WB-1:0]                tgt_way_q;
  logic [WB-1:0]                tgt_rank_q;
  logic                         result_valid_q;
  logic                         found_q;
  logic                         hit_q;
  logic [VALUE_BITS-1:0]        rdata_q;
  logic                         evicted_q;
  logic [KEY_BITS-1:0]          ekey_q;

  lkv_pkg::way_ctl_t            way_ctl;
  lkv_pkg::bk_ctl_t             bk_ctl;
  logic [WB-1:0]                way_rd_addr;
  logic [WB-1:0]                way_wr_addr;
  logic [VALUE_BITS-1:0]        way_wr_data;
  logic [WB-1:0]                way_wr_rank;
  logic [KEY_BITS-1:0]          rd_key;
  logic [VALUE_BITS-1:0]        rd_data;
  logic [WB-1:0]                rd_rank;
  logic [WAYS-1:0]              valid;
  logic [VALUE_BITS-1:0]        bk_data;
  logic                         bk_present;
  logic                         clearing;

  logic                         accept;
  logic [WB-1:0]                pidx;
  logic                         pvalid;
  logic                         key_match;
  logic [7:0]                   cap_ext;
  logic [7:0]                   cap_eff;
  logic                         evict_now;
  logic                         install;
  logic [VALUE_BITS-1:0]        install_val;
  logic [WB-1:0]                new_way;
  logic                         rank_inc;

  assign busy   = (state_q != S_IDLE) || clearing;
  assign accept = start && !busy;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // shared compare unit: way under inspection, one per cycle
  assign pidx      = WB'(idx_q - 1'b1);
  assign pvalid    = valid[pidx];
  assign key_match = pvalid && (rd_key == key_q);

  // eviction and install decision
  always_comb begin
    cap_ext = 8'(cap_q);
    if (cap_ext == 8'd0) begin
      cap_eff = 8'd1;
    end else if (cap_ext > WaysW) begin
      cap_eff = WaysW;
    end else begin
      cap_eff = cap_ext;
    end
    evict_now   = (8'(cnt_q) >= cap_eff) && (cnt_q != '0);
    install     = !hit_found_q && ((op_q == lkv_pkg::OpPut) || bk_present);
    install_val = (op_q == lkv_pkg::OpPut) ? value_q : bk_data;
    if (!evict_now) begin
      new_way = free_way_q;
    end else if (free_found_q && (free_way_q < vic_way_q)) begin
      new_way = free_way_q;
    end else begin
      new_way = vic_way_q;
    end
  end

  // rank update rule for the way under inspection
  assign rank_inc = pvalid && (mode_install_q || (rd_rank < tgt_rank_q));

  // memory port controls
  always_comb begin
    way_ctl     = '0;
    bk_ctl      = '0;
    way_rd_addr = idx_q[WB-1:0];
    way_wr_addr = pidx;
    way_wr_data = value_q;
    way_wr_rank = '0;
    unique case (state_q)
      S_IDLE: begin
        bk_ctl.rd_en = accept;
      end
      S_DECIDE: begin
        way_rd_addr = hit_way_q;
        if (hit_found_q) begin
          way_ctl.entry_we = (op_q == lkv_pkg::OpPut);
          way_wr_addr      = hit_way_q;
          bk_ctl.wr_en     = (op_q == lkv_pkg::OpPut);
        end else if (install) begin
          way_ctl.entry_we  = 1'b1;
          way_ctl.set_valid = 1'b1;
          way_ctl.clr_valid = evict_now;
          way_wr_addr       = new_way;
          way_wr_data       = install_val;
          bk_ctl.wr_en      = 1'b1;
        end
      end
      S_RANK: begin
        way_ctl.rank_we = (idx_q != '0);
        if (pidx == tgt_way_q) begin
          way_wr_rank = '0;
        end else if (rank_inc) begin
          way_wr_rank = WB'(rd_rank + 1'b1);
        end else begin
          way_wr_rank = rd_rank;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      idx_q          <= '0;
      op_q           <= lkv_pkg::OpGet;
      key_q          <= '0;
      value_q        <= '0;
      hit_found_q    <= 1'b0;
      hit_way_q      <= '0;
      hit_rank_q     <= '0;
      cnt_q          <= '0;
      vic_found_q    <= 1'b0;
      vic_way_q      <= '0;
      vic_rank_q     <= '0;
      vic_key_q      <= '0;
      free_found_q   <= 1'b0;
      free_way_q     <= '0;
      mode_install_q <= 1'b0;
      tgt_way_q      <= '0;
      tgt_rank_q     <= '0;
      result_valid_q <= 1'b0;
      found_q        <= 1'b0;
      hit_q          <= 1'b0;
      rdata_q        <= '0;
      evicted_q      <= 1'b0;
      ekey_q         <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          result_valid_q <= 1'b0;
          if (accept) begin
            op_q         <= operation_i;
            key_q        <= key_i;
            value_q      <= value_i;
            idx_q        <= '0;
            hit_found_q  <= 1'b0;
            cnt_q        <= '0;
            vic_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // inspect the way read in the previous cycle
          if (idx_q != '0) begin
            if (key_match) begin
              hit_found_q <= 1'b1;
              hit_way_q   <= pidx;
              hit_rank_q  <= rd_rank;
            end
            if (pvalid) begin
              cnt_q <= cnt_q + 1'b1;
              if (!vic_found_q || (rd_rank > vic_rank_q)) begin
                vic_found_q <= 1'b1;
                vic_way_q   <= pidx;
                vic_rank_q  <= rd_rank;
                vic_key_q   <= rd_key;
              end
            end else if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_way_q   <= pidx;
            end
          end
          if (idx_q == IdxLast) begin
            state_q <= S_DECIDE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DECIDE: begin
          idx_q <= '0;
          if (hit_found_q) begin
            found_q        <= 1'b1;
            hit_q          <= 1'b1;
            rdata_q        <= '0;
            evicted_q      <= 1'b0;
            ekey_q         <= '0;
            mode_install_q <= 1'b0;
            tgt_way_q      <= hit_way_q;
            tgt_rank_q     <= hit_rank_q;
            state_q        <= (op_q == lkv_pkg::OpGet) ? S_GRAB : S_RANK;
          end else if (install) begin
            found_q        <= 1'b1;
            hit_q          <= 1'b0;
            rdata_q        <= (op_q == lkv_pkg::OpGet) ? bk_data : '0;
            evicted_q      <= evict_now;
            ekey_q         <= evict_now ? vic_key_q : '0;
            mode_install_q <= 1'b1;
            tgt_way_q      <= new_way;
            tgt_rank_q     <= '0;
            state_q        <= S_RANK;
          end else begin
            found_q        <= 1'b0;
            hit_q          <= 1'b0;
            rdata_q        <= '0;
            evicted_q      <= 1'b0;
            ekey_q         <= '0;
            result_valid_q <= 1'b1;
            state_q        <= S_DONE;
          end
        end
        S_GRAB: begin
          rdata_q <= rd_data;
          state_q <= S_RANK;
        end
        S_RANK: begin
          if (idx_q == IdxLast) begin
            result_valid_q <= 1'b1;
            state_q        <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DONE: begin
          result_valid_q <= 1'b0;
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  lkv_way_store #(
    .WAYS       (WAYS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ways (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (way_ctl),
    .rd_addr_i  (way_rd_addr),
    .wr_addr_i  (way_wr_addr),
    .clr_addr_i (vic_way_q),
    .wr_key_i   (key_q),
    .wr_data_i  (way_wr_data),
    .wr_rank_i  (way_wr_rank),
    .rd_key_o   (rd_key),
    .rd_data_o  (rd_data),
    .rd_rank_o  (rd_rank),
    .valid_o    (valid)
  );

  lkv_backing_store #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_backing (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (bk_ctl),
    .rd_addr_i    (key_i),
    .wr_addr_i    (key_q),
    .wr_data_i    (install_val),
    .rd_data_o    (bk_data),
    .rd_present_o (bk_present),
    .clearing_o   (clearing)
  );

  assign result_valid_o = result_valid_q;
  assign found_o        = found_q;
  assign hit_o          = hit_q;
  assign read_data_o    = rdata_q;
  assign evicted_o      = evicted_q;
  assign evicted_key_o  = ekey_q;

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // an accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // a cache hit is always reported as found
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> found_o)
    else $error("hit reported without found");

  // a miss with nothing found reports no eviction and zero read data
  a_notfound_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (!evicted_o && (read_data_o == '0)))
    else $error("not-found result carries data or an eviction");

endmodule

// File: rtl/lkv_backing_store.sv
// write-through backing store with present bits and a clearing sweep after reset
module lkv_backing_store #(
  parameter int unsigned KEY_BITS   = lkv_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = lkv_pkg::ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lkv_pkg::bk_ctl_t      ctl_i,
  input  logic [KEY_BITS-1:0]   rd_addr_i,
  input  logic [KEY_BITS-1:0]   wr_addr_i,
  input  logic [VALUE_BITS-1:0] wr_data_i,
  output logic [VALUE_BITS-1:0] rd_data_o,
  output logic                  rd_present_o,
  output logic                  clearing_o
);

  localparam int unsigned Depth = 1 << KEY_BITS;

  logic [VALUE_BITS:0]   mem_q [Depth];
  logic [VALUE_BITS:0]   rd_q;
  logic [KEY_BITS-1:0]   clr_cnt_q;
  logic                  clearing_q;
  logic                  we;
  logic [KEY_BITS-1:0]   wa;
  logic [VALUE_BITS:0]   wd;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // write port shared between the sweep and write-through
  always_comb begin
    if (clearing_q) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd = '0;
    end else begin
      we = ctl_i.wr_en;
      wa = wr_addr_i;
      wd = {1'b1, wr_data_i};
    end
  end

  // storage with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_q[VALUE_BITS-1:0];
  assign rd_present_o = rd_q[VALUE_BITS];
  assign clearing_o   = clearing_q;

endmodule

// File: rtl/lkv_way_store.sv
// cache ways: key, data and rank memories plus valid flags
module lkv_way_store #(
  parameter int unsigned WAYS       = lkv_pkg::WaysDef,
  parameter int unsigned KEY_BITS   = lkv_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = lkv_pkg::ValueBitsDef,
  localparam int unsigned WB        = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lkv_pkg::way_ctl_t     ctl_i,
  input  logic [WB-1:0]         rd_addr_i,
  input  logic [WB-1:0]         wr_addr_i,
  input  logic [WB-1:0]         clr_addr_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_data_i,
  input  logic [WB-1:0]         wr_rank_i,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [VALUE_BITS-1:0] rd_data_o,
  output logic [WB-1:0]         rd_rank_o,
  output logic [WAYS-1:0]       valid_o
);

  logic [KEY_BITS-1:0]   key_mem_q  [WAYS];
  logic [VALUE_BITS-1:0] data_mem_q [WAYS];
  logic [WB-1:0]         rank_mem_q [WAYS];
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_data_q;
  logic [WB-1:0]         rd_rank_q;
  logic [WAYS-1:0]       valid_q;
  logic [WAYS-1:0]       valid_d;

  // entry and rank memories, read every cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.entry_we) begin
      key_mem_q[wr_addr_i]  <= wr_key_i;
      data_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rank_we) begin
      rank_mem_q[wr_addr_i] <= wr_rank_i;
    end
    rd_key_q  <= key_mem_q[rd_addr_i];
    rd_data_q <= data_mem_q[rd_addr_i];
    rd_rank_q <= rank_mem_q[rd_addr_i];
  end

  // next valid flags, set wins over the eviction clear
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clr_valid) begin
      valid_d[clr_addr_i] = 1'b0;
    end
    if (ctl_i.set_valid) begin
      valid_d[wr_addr_i] = 1'b1;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_key_o  = rd_key_q;
  assign rd_data_o = rd_data_q;
  assign rd_rank_o = rd_rank_q;
  assign valid_o   = valid_q;

endmodule
